FILE: hdl/lpms_pkg.sv
`timescale 1ns / 1ps

package lpms_pkg;

   // Pattern modes
   localparam logic [2:0] MODE_ALT       = 3'd0;
   localparam logic [2:0] MODE_DUAL      = 3'd1;
   localparam logic [2:0] MODE_FAST      = 3'd2;
   localparam logic [2:0] MODE_FADE      = 3'd3;
   localparam logic [2:0] MODE_COUNTDOWN = 3'd4;

   localparam logic [7:0] LED_ON  = 8'd255;
   localparam logic [7:0] LED_OFF = 8'd0;

   // Countdown phase limits in elapsed milliseconds
   localparam logic [31:0] CD_BLINK_END = 32'd5000;
   localparam logic [31:0] CD_ON_END    = 32'd6000;
   localparam logic [31:0] CD_OFF_END   = 32'd8000;
   localparam logic [10:0] CD_MIN_DIV   = 11'd10;

   // Blink quotient: dividend up to 5000 needs 13 bits, divisor up to 1250 needs 11
   localparam int DVD_W = 13;
   localparam int DSR_W = 11;
   localparam logic [3:0] DIV_LAST = 4'(DVD_W - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_FINISH
   } seq_state_type;

endpackage

FILE: hdl/lpms_if.sv
`timescale 1ns / 1ps

interface lpms_req_if;
   logic valid;
   logic ready;
   logic button_level;

   modport source (output valid, output button_level, input ready);
   modport sink   (input valid, input button_level, output ready);
endinterface

interface lpms_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] led1_level;
   logic [7:0] led2_level;
   logic [2:0] mode;

   modport source (output valid, output led1_level, output led2_level, output mode,
                   input ready);
   modport sink   (input valid, input led1_level, input led2_level, input mode,
                   output ready);
endinterface

FILE: hdl/led_pattern_mode_sequencer_core.sv
`timescale 1ns / 1ps

// LED pattern sequencer: each item on req_chan is one millisecond tick carrying the raw
// active-low button level, and each tick returns exactly one item on rsp_chan with two
// LED brightness levels and the mode that produced them. A rising press advances the
// mode 0->1->2->3->4->0 from the next tick on; mode 4 is a countdown that ends by
// itself in mode 0. Writing csr_wr_data with csr_wr_en while idle loads the mode (5 to 7
// load as 0; 4 restarts the countdown); a write outside idle is lost. A tick goes
// through setup and finish before the next ready; during the countdown blink phase
// the blink parity is found between them by a one-bit-per-cycle restoring divider
// over 13 quotient bits. The result sits in an output register, so the finish step
// waits only when that register is still full and not being taken.
module led_pattern_mode_sequencer_core
   import lpms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lpms_req_if.sink    req_chan,
   lpms_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data
);

   seq_state_type state_ff, state_in;

   logic [31:0] ms_count_ff, ms_count_in;
   logic [31:0] cd_start_ff, cd_start_in;
   logic [2:0]  mode_ff, mode_in;
   logic        held_ff, held_in;

   // Per-tick working registers
   logic             pressed_ff, pressed_in;
   logic [31:0]      elapsed_ff, elapsed_in;
   logic [DVD_W-1:0] dvd_ff, dvd_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic             qbit_ff, qbit_in;
   logic [3:0]       cnt_ff, cnt_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] led1_ff, led1_in;
   logic [7:0] led2_ff, led2_in;
   logic [2:0] rsp_mode_ff, rsp_mode_in;

   logic             req_take;
   logic             out_free;
   logic [2:0]       mode_eff;
   logic [2:0]       mode_next;
   logic [2:0]       csr_mode;
   logic [DVD_W-1:0] blink_left;
   logic [DSR_W-1:0] blink_div;
   logic [DSR_W:0]   trial;
   logic             trial_ge;
   logic [7:0]       fade_lv;
   logic [7:0]       lv1, lv2;

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign req_take            = req_chan.valid && req_chan.ready;
   assign out_free            = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.led1_level = led1_ff;
   assign rsp_chan.led2_level = led2_ff;
   assign rsp_chan.mode       = rsp_mode_ff;

   assign csr_mode = (csr_wr_data > MODE_COUNTDOWN) ? MODE_ALT : csr_wr_data;

   // Blink period: quarter of the time left, never below the minimum
   assign blink_left = DVD_W'(CD_BLINK_END) - elapsed_ff[DVD_W-1:0];
   assign blink_div  = (blink_left[DVD_W-1:2] < CD_MIN_DIV) ? CD_MIN_DIV
                                                            : blink_left[DVD_W-1:2];

   // One restoring division step: shift in the next dividend bit, subtract if it fits
   assign trial    = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial_ge = (trial >= {1'b0, dsr_ff});

   // Countdown past its end drops back to mode 0 in the same tick
   always_comb begin
      mode_eff = (mode_ff > MODE_COUNTDOWN) ? MODE_ALT : mode_ff;
      if (mode_eff == MODE_COUNTDOWN && elapsed_ff >= CD_OFF_END) begin
         mode_eff = MODE_ALT;
      end
      mode_next = (mode_eff >= MODE_COUNTDOWN) ? MODE_ALT : 3'(mode_eff + 3'd1);
   end

   // Fade: rising c/4 over the first half, falling over the second
   assign fade_lv = ms_count_ff[10] ? ~ms_count_ff[9:2] : ms_count_ff[9:2];

   always_comb begin
      lv1 = LED_OFF;
      lv2 = LED_OFF;
      case (mode_eff)
         MODE_ALT: begin
            lv1 = ms_count_ff[10] ? LED_ON : LED_OFF;
            lv2 = ms_count_ff[10] ? LED_OFF : LED_ON;
         end
         MODE_DUAL: begin
            lv1 = ms_count_ff[10] ? LED_ON : LED_OFF;
            lv2 = ms_count_ff[8] ? LED_OFF : LED_ON;
         end
         MODE_FAST: begin
            lv1 = ms_count_ff[5] ? LED_ON : LED_OFF;
            lv2 = ms_count_ff[9] ? LED_ON : LED_OFF;
         end
         MODE_FADE: begin
            lv1 = fade_lv;
            lv2 = ~fade_lv;
         end
         MODE_COUNTDOWN: begin
            if (elapsed_ff <= CD_BLINK_END) begin
               lv1 = qbit_ff ? LED_ON : LED_OFF;
               lv2 = qbit_ff ? LED_OFF : LED_ON;
            end else if (elapsed_ff < CD_ON_END) begin
               lv1 = LED_ON;
               lv2 = LED_ON;
            end
         end
         default: begin
            lv1 = LED_OFF;
            lv2 = LED_OFF;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ms_count_ff  <= '0;
         cd_start_ff  <= '0;
         mode_ff      <= MODE_ALT;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ms_count_ff  <= ms_count_in;
         cd_start_ff  <= cd_start_in;
         mode_ff      <= mode_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pressed_ff  <= pressed_in;
      elapsed_ff  <= elapsed_in;
      dvd_ff      <= dvd_in;
      dsr_ff      <= dsr_in;
      rem_ff      <= rem_in;
      qbit_ff     <= qbit_in;
      cnt_ff      <= cnt_in;
      led1_ff     <= led1_in;
      led2_ff     <= led2_in;
      rsp_mode_ff <= rsp_mode_in;
   end

   always_comb begin
      state_in     = state_ff;
      ms_count_in  = ms_count_ff;
      cd_start_in  = cd_start_ff;
      mode_in      = mode_ff;
      held_in      = held_ff;
      pressed_in   = pressed_ff;
      elapsed_in   = elapsed_ff;
      dvd_in       = dvd_ff;
      dsr_in       = dsr_ff;
      rem_in       = rem_ff;
      qbit_in      = qbit_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      led1_in      = led1_ff;
      led2_in      = led2_ff;
      rsp_mode_in  = rsp_mode_ff;

      // Drop the result once the sink takes it
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // Writes land only while idle; load the mode and restart the countdown on 4
            if (csr_wr_en) begin
               mode_in = csr_mode;
               if (csr_mode == MODE_COUNTDOWN) begin
                  cd_start_in = ms_count_ff;
               end
            end
            if (req_take) begin
               pressed_in = !req_chan.button_level;
               elapsed_in = ms_count_ff - cd_start_ff;
               state_in   = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // Only the blink phase needs the quotient parity
            if (mode_ff == MODE_COUNTDOWN && elapsed_ff <= CD_BLINK_END) begin
               dvd_in   = elapsed_ff[DVD_W-1:0];
               dsr_in   = blink_div;
               rem_in   = '0;
               cnt_in   = DIV_LAST;
               state_in = ST_DIVIDE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            // Advance one quotient bit; the last one decides which LED is lit
            rem_in  = trial_ge ? DSR_W'(trial - {1'b0, dsr_ff}) : trial[DSR_W-1:0];
            qbit_in = trial_ge;
            dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
            cnt_in  = cnt_ff - 4'd1;
            if (cnt_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold here until the output register has room
            if (out_free) begin
               rsp_valid_in = 1'b1;
               led1_in      = lv1;
               led2_in      = lv2;
               rsp_mode_in  = mode_eff;
               mode_in      = mode_eff;
               if (pressed_ff && !held_ff) begin
                  held_in = 1'b1;
                  mode_in = mode_next;
                  if (mode_next == MODE_COUNTDOWN) begin
                     cd_start_in = ms_count_ff;
                  end
               end else if (!pressed_ff && held_ff) begin
                  held_in = 1'b0;
               end
               ms_count_in = ms_count_ff + 32'd1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/lpms_checker.sv
`timescale 1ns / 1ps

module lpms_checker
   import lpms_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_led1_level,
   input logic [7:0] rsp_led2_level,
   input logic [2:0] rsp_mode
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_led1_level) && $stable(rsp_led2_level) && $stable(rsp_mode))
      else $error("result item changed while stalled");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mode <= MODE_COUNTDOWN)
      else $error("result mode out of range");

   a_complement: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_mode == MODE_ALT || rsp_mode == MODE_FADE)
         |-> rsp_led1_level == ~rsp_led2_level)
      else $error("levels not complementary in alternate or fade mode");

endmodule

bind led_pattern_mode_sequencer_core lpms_checker u_lpms_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_led1_level (rsp_chan.led1_level),
   .rsp_led2_level (rsp_chan.led2_level),
   .rsp_mode       (rsp_chan.mode)
);

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb
   import lpms_pkg::*;
;

   localparam int QUIET_LIMIT = 3000;   // cycles with no item moving before giving up
   localparam int STALL_SPAN  = 150;    // receiver hold-off used to back up the block
   localparam int SETTLE      = 20;     // idle cycles before a register write or the end
   localparam int CD_RUN      = 200;    // untouched countdown ticks before pressing out

   typedef struct packed {
      logic [7:0] led1;
      logic [7:0] led2;
      logic [2:0] mode;
   } led_frame_type;

   // Tracks the sequencer state and holds the LED frames still owed by the block.
   class pattern_tracker;
      logic [2:0]    start_mode;
      logic [31:0]   tick_count;
      logic [2:0]    cur_mode;
      bit            held;
      logic [31:0]   cd_start;
      led_frame_type owed_frames[$];
      int            errors;

      function new();
         start_mode = MODE_ALT;
         tick_count = '0;
         cur_mode   = MODE_ALT;
         held       = 1'b0;
         cd_start   = '0;
         errors     = 0;
      endfunction

      function void enter(logic [2:0] m);
         cur_mode = m;
         if (m == MODE_COUNTDOWN) cd_start = tick_count;
      endfunction

      function void load_start(logic [2:0] v);
         start_mode = v;
         enter((v > MODE_COUNTDOWN) ? MODE_ALT : v);
      endfunction

      function void note_tick(logic button);
         logic [31:0]   elapsed;
         logic [31:0]   span;
         logic [31:0]   t;
         logic [7:0]    l1;
         logic [7:0]    l2;
         led_frame_type frame;
         t  = tick_count;
         l1 = LED_OFF;
         l2 = LED_OFF;
         if (cur_mode > MODE_COUNTDOWN) cur_mode = MODE_ALT;
         if (cur_mode == MODE_COUNTDOWN) begin
            elapsed = t - cd_start;
            if (elapsed <= CD_BLINK_END) begin
               span = (CD_BLINK_END - elapsed) >> 2;
               if (span < 32'(CD_MIN_DIV)) span = 32'(CD_MIN_DIV);
               if (((elapsed / span) & 32'd1) != 0) begin
                  l1 = LED_ON;
                  l2 = LED_OFF;
               end else begin
                  l1 = LED_OFF;
                  l2 = LED_ON;
               end
            end else if (elapsed < CD_ON_END) begin
               l1 = LED_ON;
               l2 = LED_ON;
            end else if (elapsed < CD_OFF_END) begin
               l1 = LED_OFF;
               l2 = LED_OFF;
            end else begin
               cur_mode = MODE_ALT;
            end
         end
         case (cur_mode)
            MODE_ALT: begin
               l1 = t[10] ? LED_ON : LED_OFF;
               l2 = t[10] ? LED_OFF : LED_ON;
            end
            MODE_DUAL: begin
               l1 = t[10] ? LED_ON : LED_OFF;
               l2 = t[8] ? LED_OFF : LED_ON;
            end
            MODE_FAST: begin
               l1 = t[5] ? LED_ON : LED_OFF;
               l2 = t[9] ? LED_ON : LED_OFF;
            end
            MODE_FADE: begin
               l1 = t[10] ? (LED_ON - t[9:2]) : t[9:2];
               l2 = LED_ON - l1;
            end
            default: begin
            end
         endcase
         frame.led1 = l1;
         frame.led2 = l2;
         frame.mode = cur_mode;
         owed_frames.push_back(frame);
         if (!button && !held) begin
            held = 1'b1;
            enter((cur_mode >= MODE_COUNTDOWN) ? MODE_ALT : cur_mode + 3'd1);
         end else if (button && held) begin
            held = 1'b0;
         end
         tick_count = t + 32'd1;
      endfunction

      function void check_frame(logic [7:0] l1, logic [7:0] l2, logic [2:0] m);
         led_frame_type want;
         if (owed_frames.size() == 0) begin
            $display("%0t: unexpected item led1=%0d led2=%0d mode=%0d", $time, l1, l2, m);
            errors++;
            return;
         end
         want = owed_frames.pop_front();
         if (l1 !== want.led1) begin
            $display("%0t: led1 expected %0d actual %0d", $time, want.led1, l1);
            errors++;
         end
         if (l2 !== want.led2) begin
            $display("%0t: led2 expected %0d actual %0d", $time, want.led2, l2);
            errors++;
         end
         if (m !== want.mode) begin
            $display("%0t: mode expected %0d actual %0d", $time, want.mode, m);
            errors++;
         end
      endfunction

      function int pending();
         return owed_frames.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [2:0] csr_wr_data;

   bit tx_steady;      // sender offers back to back
   bit rx_steady;      // receiver takes every cycle
   bit stall_rsp_req;  // ask the receiver for one long hold-off

   pattern_tracker tracker;

   lpms_req_if req_if();
   lpms_rsp_if rsp_if();

   led_pattern_mode_sequencer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: take items at random, hold off once on request, or take every cycle.
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_rsp_req) begin
            // hold off long enough for the block to fill and push back on its input
            rsp_if.ready <= 1'b0;
            stall_rsp_req = 1'b0;
            repeat (STALL_SPAN) @(posedge clock);
         end else begin
            rsp_if.ready <= rx_steady || ($urandom_range(99) >= 23);
         end
      end
   end

   // Monitor: check results before noting the tick accepted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready)
            tracker.check_frame(rsp_if.led1_level, rsp_if.led2_level, rsp_if.mode);
         if (req_if.valid && req_if.ready)
            tracker.note_tick(req_if.button_level);
      end
   end

   // Watchdog: end the run if no item moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // Offer one tick, idling first at random, and wait until it is taken.
   task automatic send_tick(input logic button);
      if (!tx_steady) begin
         while ($urandom_range(99) < 23) begin
            req_if.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_if.valid        <= 1'b1;
      req_if.button_level <= button;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Drop the request, drain, let the block settle, then write start_mode.
   task automatic load_start_mode(input logic [2:0] value);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      tracker.load_start(value);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly clean presses (release run, then a held press) with some bouncing noise.
   task automatic run_button_traffic(input int count);
      int sent;
      int run;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 80) begin
            run = $urandom_range(40, 1);
            repeat (run) send_tick(1'b1);
            sent += run;
            run = $urandom_range(6, 1);
            repeat (run) send_tick(1'b0);
            sent += run;
         end else begin
            run = $urandom_range(8, 1);
            repeat (run) send_tick(1'($urandom_range(1, 0)));
            sent += run;
         end
      end
   endtask

   initial begin
      tracker             = new();
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = MODE_ALT;
      req_if.valid        = 1'b0;
      req_if.button_level = 1'b1;
      tx_steady           = 1'b0;
      rx_steady           = 1'b0;
      stall_rsp_req       = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Walk every mode by press, hold a press, wrap out of the countdown by press.
      send_tick(1'b1);
      send_tick(1'b0);   // press: alternate -> dual
      send_tick(1'b0);   // still held, no advance
      send_tick(1'b1);
      send_tick(1'b0);   // dual -> fast
      send_tick(1'b1);
      send_tick(1'b0);   // fast -> fade
      send_tick(1'b1);
      send_tick(1'b0);   // fade -> countdown
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);   // countdown -> alternate by press
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      send_tick(1'b1);

      // Invalid start modes load as mode 0.
      load_start_mode(3'd7);
      send_tick(1'b1);
      send_tick(1'b1);
      run_button_traffic(100);

      // Countdown loaded by register write starts at zero elapsed time.
      load_start_mode(MODE_COUNTDOWN);
      run_button_traffic(120);

      // Long stretch with no idling on either side.
      load_start_mode(MODE_FADE);
      tx_steady = 1'b1;
      rx_steady = 1'b1;
      run_button_traffic(250);
      rx_steady = 1'b0;

      // Back up the block: receiver holds off while the sender keeps offering.
      load_start_mode(MODE_FAST);
      stall_rsp_req = 1'b1;
      run_button_traffic(200);
      tx_steady = 1'b0;

      load_start_mode(MODE_DUAL);
      run_button_traffic(120);
      load_start_mode(3'd5);
      run_button_traffic(80);
      load_start_mode(3'd6);
      run_button_traffic(60);
      load_start_mode(MODE_ALT);
      run_button_traffic(100);

      // Run the countdown blinks untouched for a while, then press out of it.
      load_start_mode(MODE_COUNTDOWN);
      repeat (CD_RUN) send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);

      // Drain, then let the block settle before the verdict.
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         if (tracker.pending() != 0)
            $display("%0t: %0d results never arrived", $time, tracker.pending());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
